/* rtl/rrs_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin schedule simulator package
// Shared item types, controller states, command and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

  // Default process capacity of the list memories
  localparam int unsigned MaxProcsDefault = 16;

  // Field widths
  localparam int unsigned ValW  = 16;
  localparam int unsigned TimeW = 21;
  localparam int unsigned PidW  = 4;

  // Register file: word address bit of paddr and register codes
  localparam int unsigned PaddrW         = 3;
  localparam logic        RegTimeQuantum = 1'b0;

  // One loaded process
  typedef struct packed {
    logic [ValW-1:0] arrival_time;
    logic [ValW-1:0] burst_time;
    logic            last_item;
  } in_item_t;

  // One per-process result
  typedef struct packed {
    logic [PidW-1:0]  proc_index;
    logic [TimeW-1:0] response_time;
    logic [TimeW-1:0] turnaround_time;
    logic [TimeW-1:0] waiting_time;
    logic             last_result;
  } out_item_t;

  // Controller states
  typedef enum logic [3:0] {
    StIdle,
    StAdmRd,
    StAdmCmp,
    StCheck,
    StPop,
    StDisp,
    StFinish,
    StOutRd,
    StOutEmit
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic adm_check;
    logic jump_time;
    logic pop;
    logic dispatch;
    logic finish;
    logic out_read;
    logic out_emit;
    logic clear;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done_all;
    logic arr_pending;
    logic adm_ok;
    logic queue_empty;
    logic out_last;
  } dp_status_t;

endpackage : rrs_pkg

`default_nettype wire

/* rtl/rrs_datapath.sv */
// ----------------------------------------------------------------------------
// Round-robin schedule simulator datapath
// Process memories, circular ready queue, time and count registers, and the
// result register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrs_datapath import rrs_pkg::*; #(
  parameter int unsigned MaxProcs = MaxProcsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire in_item_t        item_i,
  input  wire logic [ValW-1:0] quantum_i,
  input  wire dp_cmd_t         cmd_i,
  output dp_status_t           status_o,
  output out_item_t            result_o,
  output logic                 result_strobe_o
);

  localparam int unsigned IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CntW = $clog2(MaxProcs + 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MaxProcs);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxProcs - 1);

  // Memories
  logic [2*ValW-1:0] proc_mem  [MaxProcs];
  logic [ValW-1:0]   rem_mem   [MaxProcs];
  logic [TimeW-1:0]  resp_mem  [MaxProcs];
  logic [TimeW-1:0]  turn_mem  [MaxProcs];
  logic [IdxW-1:0]   queue_mem [MaxProcs];

  // Control registers
  logic [CntW-1:0]     loaded_q, next_arr_q, completed_q, count_q;
  logic [IdxW-1:0]     head_q, tail_q, out_k_q;
  logic [TimeW-1:0]    cur_time_q;
  logic [MaxProcs-1:0] started_q;

  // Payload registers
  logic [IdxW-1:0]   idx_q, queue_rd_q;
  logic [2*ValW-1:0] proc_rd_q;
  logic [ValW-1:0]   rem_rd_q, wake_time_q, cur_arr_q, rem_left_q;
  logic [TimeW-1:0]  resp_rd_q, turn_rd_q;
  out_item_t         result_q;
  logic              strobe_q;

  // Combinational helpers
  logic            load_ok;
  logic [IdxW-1:0] head_inc, tail_inc, proc_raddr, push_idx;
  logic            push_en;
  logic [ValW-1:0] rd_arrival, rd_burst, slice, rem_new;
  logic            rem_we;
  logic [IdxW-1:0] rem_waddr;
  logic [ValW-1:0] rem_wdata;
  logic            finish_done;
  logic [TimeW-1:0] wait_time;

  assign rd_arrival = proc_rd_q[2*ValW-1:ValW];
  assign rd_burst   = proc_rd_q[ValW-1:0];
  assign load_ok    = cmd_i.load && (loaded_q < MaxCnt);
  assign head_inc   = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_inc   = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

  // Slice is the smaller of the remaining work and the quantum
  assign slice   = (rem_rd_q > quantum_i) ? quantum_i : rem_rd_q;
  assign rem_new = rem_rd_q - slice;

  assign finish_done = cmd_i.finish && (rem_left_q == '0);

  // Push new arrivals, or put a preempted process back at the tail
  always_comb begin
    push_en  = 1'b0;
    push_idx = idx_q;
    if (cmd_i.adm_check && status_o.adm_ok) begin
      push_en  = 1'b1;
      push_idx = next_arr_q[IdxW-1:0];
    end else if (cmd_i.finish && (rem_left_q != '0)) begin
      push_en  = 1'b1;
    end
  end

  // Shared read address of the process and remaining-work memories
  always_comb begin
    if (cmd_i.pop) begin
      proc_raddr = queue_rd_q;
    end else if (cmd_i.out_read) begin
      proc_raddr = out_k_q;
    end else begin
      proc_raddr = next_arr_q[IdxW-1:0];
    end
  end

  // Single write port of the remaining-work memory
  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = idx_q;
    rem_wdata = rem_new;
    if (load_ok) begin
      rem_we    = 1'b1;
      rem_waddr = loaded_q[IdxW-1:0];
      rem_wdata = item_i.burst_time;
    end else if (cmd_i.dispatch) begin
      rem_we    = 1'b1;
    end
  end

  assign wait_time = turn_rd_q - TimeW'(rd_burst);

  // Status back to the controller
  always_comb begin
    status_o.done_all    = (completed_q == loaded_q);
    status_o.arr_pending = (next_arr_q < loaded_q);
    status_o.adm_ok      = (TimeW'(rd_arrival) <= cur_time_q);
    status_o.queue_empty = (count_q == '0);
    status_o.out_last    = ((CntW'(out_k_q) + CntW'(1)) == loaded_q);
  end

  // Counters, queue pointers, clock and started flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      next_arr_q  <= '0;
      completed_q <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_k_q     <= '0;
      cur_time_q  <= '0;
      started_q   <= '0;
      strobe_q    <= 1'b0;
    end else begin
      strobe_q <= cmd_i.out_emit;
      if (cmd_i.clear) begin
        loaded_q    <= '0;
        next_arr_q  <= '0;
        completed_q <= '0;
        count_q     <= '0;
        head_q      <= '0;
        tail_q      <= '0;
        out_k_q     <= '0;
        cur_time_q  <= '0;
        started_q   <= '0;
      end else begin
        if (load_ok) begin
          loaded_q <= loaded_q + 1'b1;
        end
        if (push_en) begin
          tail_q  <= tail_inc;
          count_q <= count_q + 1'b1;
        end
        if (cmd_i.pop) begin
          head_q  <= head_inc;
          count_q <= count_q - 1'b1;
        end
        if (cmd_i.adm_check && status_o.adm_ok) begin
          next_arr_q <= next_arr_q + 1'b1;
        end
        if (cmd_i.jump_time) begin
          cur_time_q <= TimeW'(wake_time_q);
        end
        if (cmd_i.dispatch) begin
          cur_time_q        <= cur_time_q + TimeW'(slice);
          started_q[idx_q]  <= 1'b1;
        end
        if (finish_done) begin
          completed_q <= completed_q + 1'b1;
        end
        if (cmd_i.out_emit) begin
          out_k_q <= out_k_q + 1'b1;
        end
      end
    end
  end

  // Memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      proc_mem[loaded_q[IdxW-1:0]] <= {item_i.arrival_time, item_i.burst_time};
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (push_en) begin
      queue_mem[tail_q] <= push_idx;
    end
    if (cmd_i.dispatch && !started_q[idx_q]) begin
      resp_mem[idx_q] <= cur_time_q - TimeW'(rd_arrival);
    end
    if (finish_done) begin
      turn_mem[idx_q] <= cur_time_q - TimeW'(cur_arr_q);
    end
    proc_rd_q  <= proc_mem[proc_raddr];
    rem_rd_q   <= rem_mem[proc_raddr];
    resp_rd_q  <= resp_mem[out_k_q];
    turn_rd_q  <= turn_mem[out_k_q];
    queue_rd_q <= queue_mem[head_q];
  end

  // Dispatch bookkeeping and the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      idx_q <= queue_rd_q;
    end
    if (cmd_i.adm_check && !status_o.adm_ok) begin
      wake_time_q <= rd_arrival;
    end
    if (cmd_i.dispatch) begin
      cur_arr_q  <= rd_arrival;
      rem_left_q <= rem_new;
    end
    if (cmd_i.out_emit) begin
      result_q.proc_index      <= PidW'(out_k_q);
      result_q.response_time   <= resp_rd_q;
      result_q.turnaround_time <= turn_rd_q;
      result_q.waiting_time    <= wait_time;
      result_q.last_result     <= status_o.out_last;
    end
  end

  assign result_o        = result_q;
  assign result_strobe_o = strobe_q;

endmodule : rrs_datapath

`default_nettype wire

/* rtl/rrs_ctrl.sv */
// ----------------------------------------------------------------------------
// Round-robin schedule simulator controller
// Sequences loading, the admit/dispatch loop and the result readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrs_ctrl import rrs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic       last_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o
);

  state_e state_q, state_d;
  // Admit pass after a slice rather than at the top of the loop
  logic   post_q, post_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      post_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      post_q  <= post_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    post_d  = post_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            post_d  = 1'b0;
            state_d = StAdmRd;
          end
        end
      end
      StAdmRd: begin
        if (!post_q && status_i.done_all) begin
          state_d = StOutRd;
        end else if (status_i.arr_pending) begin
          state_d = StAdmCmp;
        end else begin
          state_d = post_q ? StFinish : StCheck;
        end
      end
      StAdmCmp: begin
        cmd_o.adm_check = 1'b1;
        if (status_i.adm_ok) begin
          state_d = StAdmRd;
        end else begin
          state_d = post_q ? StFinish : StCheck;
        end
      end
      StCheck: begin
        if (!status_i.queue_empty) begin
          state_d = StPop;
        end else if (status_i.arr_pending) begin
          // idle gap: jump the clock to the next arrival
          cmd_o.jump_time = 1'b1;
          state_d         = StAdmRd;
        end else begin
          state_d = StOutRd;
        end
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        state_d   = StDisp;
      end
      StDisp: begin
        cmd_o.dispatch = 1'b1;
        post_d         = 1'b1;
        state_d        = StAdmRd;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        post_d       = 1'b0;
        state_d      = StAdmRd;
      end
      StOutRd: begin
        cmd_o.out_read = 1'b1;
        state_d        = StOutEmit;
      end
      StOutEmit: begin
        cmd_o.out_emit = 1'b1;
        if (status_i.out_last) begin
          cmd_o.clear = 1'b1;
          state_d     = StIdle;
        end else begin
          state_d = StOutRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule : rrs_ctrl

`default_nettype wire

/* rtl/round_robin_schedule_sim_core.sv */
// ----------------------------------------------------------------------------
// Round-robin schedule simulator core
// Loads a process list, simulates round-robin scheduling with a programmable
// quantum and emits response, turnaround and waiting time per process.
//
//   Channel  | Ports                                   | Handshake
//   ---------+-----------------------------------------+--------------------
//   input    | start, busy, item_i                     | start && !busy
//   result   | result_strobe_o, result_o               | strobe, one cycle
//   config   | psel, penable, pwrite, paddr, pwdata,   | APB write access
//            | prdata, pready                          | phase, pready = 1
//
// Loading accepts one item per cycle; busy stays low while the list fills.
// The item flagged last starts the simulation: each admitted arrival takes
// a memory read and a compare state. A dispatch steps through queue check,
// pop, slice, post-slice admit read, requeue or retire, loop-top admit read,
// plus a failed compare after the slice and one at the top of the loop while
// a later arrival is still pending. An idle clock jump is made in the queue
// check state. Readout then takes a read and an emit state per process, for
// the registered memory read ports. All list state is cleared on the last
// result; no clearing pass is needed after reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module round_robin_schedule_sim_core import rrs_pkg::*; #(
  parameter int unsigned MaxProcs = MaxProcsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          item_i,
  output logic                   result_strobe_o,
  output out_item_t              result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [ValW-1:0] quantum_q;
  logic [ValW-1:0] quantum_eff;
  dp_cmd_t         cmd;
  dp_status_t      status;

  // Quantum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= ValW'(1);
    end else if (psel && penable && pwrite && (paddr[2] == RegTimeQuantum)) begin
      quantum_q <= pwdata[ValW-1:0];
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegTimeQuantum) begin
      prdata = {{(32-ValW){1'b0}}, quantum_q};
    end
  end

  assign pready = 1'b1;

  // A zero quantum runs as a quantum of one
  assign quantum_eff = (quantum_q == '0) ? ValW'(1) : quantum_q;

  rrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .last_i   (item_i.last_item),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  rrs_datapath #(
    .MaxProcs (MaxProcs)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item_i),
    .quantum_i       (quantum_eff),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule : round_robin_schedule_sim_core

`default_nettype wire

/* sim/round_robin_schedule_sim_core_tb.sv */
// ----------------------------------------------------------------------------
// Round-robin schedule simulator core testbench
// Loads process lists through the command port and programs the quantum over
// APB. A scoreboard replays round-robin scheduling for every list and checks
// each emitted per-process result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import rrs_pkg::*;

// Scoreboard: schedules each loaded list and queues the expected results
class schedule_scoreboard;
  localparam int Procs = 16;

  logic [ValW-1:0]  list_arrival   [Procs];
  logic [ValW-1:0]  list_remaining [Procs];
  logic [ValW-1:0]  list_burst     [Procs];
  logic [TimeW-1:0] list_response  [Procs];
  logic [TimeW-1:0] list_turnaround[Procs];
  bit               list_started   [Procs];
  logic [PidW-1:0]  ready_ring     [Procs];
  int               ring_head, ring_tail, ring_count;
  int               next_admit, retired, loaded;
  logic [TimeW-1:0] sim_clock;
  logic [ValW-1:0]  quantum;

  out_item_t        expected_times[$];
  int               mismatches;
  int               results_checked;
  int               lists_scheduled;

  function new();
    quantum = 16'd1;
    mismatches = 0;
    results_checked = 0;
    lists_scheduled = 0;
    reset_list();
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("MISMATCH: %s", what);
  endtask

  function void reset_list();
    for (int i = 0; i < Procs; i++) begin
      list_arrival[i] = '0;
      list_remaining[i] = '0;
      list_burst[i] = '0;
      list_response[i] = '0;
      list_turnaround[i] = '0;
      list_started[i] = 1'b0;
      ready_ring[i] = '0;
    end
    ring_head = 0;
    ring_tail = 0;
    ring_count = 0;
    next_admit = 0;
    retired = 0;
    loaded = 0;
    sim_clock = '0;
  endfunction

  function void push_ready(int idx);
    if (ring_count < Procs) begin
      ready_ring[ring_tail] = idx[PidW-1:0];
      ring_tail = (ring_tail + 1) % Procs;
      ring_count++;
    end
  endfunction

  // Admit arrivals strictly in load order once they are due
  function void admit_due(int n);
    while (next_admit < n && {5'd0, list_arrival[next_admit]} <= sim_clock) begin
      push_ready(next_admit);
      next_admit++;
    end
  endfunction

  function void run_schedule(int n);
    logic [ValW-1:0] q;
    logic [ValW-1:0] slice;
    int              idx;
    q = (quantum == '0) ? 16'd1 : quantum;
    while (retired < n) begin
      admit_due(n);
      // Idle CPU: jump to the next arrival
      if (ring_count == 0) begin
        if (next_admit >= n) break;
        sim_clock = {5'd0, list_arrival[next_admit]};
        continue;
      end
      idx = ready_ring[ring_head];
      ring_head = (ring_head + 1) % Procs;
      ring_count--;
      if (idx >= n) continue;
      if (!list_started[idx]) begin
        list_started[idx] = 1'b1;
        list_response[idx] = sim_clock - {5'd0, list_arrival[idx]};
      end
      slice = (list_remaining[idx] > q) ? q : list_remaining[idx];
      list_remaining[idx] = list_remaining[idx] - slice;
      sim_clock = sim_clock + {5'd0, slice};
      // New arrivals go ahead of the preempted process
      admit_due(n);
      if (list_remaining[idx] != '0) begin
        push_ready(idx);
      end else begin
        retired++;
        list_turnaround[idx] = sim_clock - {5'd0, list_arrival[idx]};
      end
    end
  endfunction

  // Note one accepted item; the last one of a list yields the results
  function void note_item(in_item_t it);
    out_item_t e;
    int        n;
    if (loaded < Procs) begin
      list_arrival[loaded] = it.arrival_time;
      list_burst[loaded] = it.burst_time;
      list_remaining[loaded] = it.burst_time;
      list_started[loaded] = 1'b0;
      loaded++;
    end
    if (!it.last_item) return;
    n = loaded;
    run_schedule(n);
    for (int k = 0; k < n; k++) begin
      e.proc_index = k[PidW-1:0];
      e.response_time = list_response[k];
      e.turnaround_time = list_turnaround[k];
      e.waiting_time = list_turnaround[k] - {5'd0, list_burst[k]};
      e.last_result = (k == n - 1);
      expected_times.push_back(e);
    end
    lists_scheduled++;
    reset_list();
  endfunction

  task check_result(out_item_t got);
    out_item_t e;
    if (expected_times.size() == 0) begin
      report_mismatch($sformatf("unexpected result for process %0d", got.proc_index));
      return;
    end
    e = expected_times.pop_front();
    results_checked++;
    if (got.proc_index !== e.proc_index)
      report_mismatch($sformatf("proc_index got %0d want %0d", got.proc_index, e.proc_index));
    if (got.response_time !== e.response_time)
      report_mismatch($sformatf("process %0d response got %0d want %0d",
                                e.proc_index, got.response_time, e.response_time));
    if (got.turnaround_time !== e.turnaround_time)
      report_mismatch($sformatf("process %0d turnaround got %0d want %0d",
                                e.proc_index, got.turnaround_time, e.turnaround_time));
    if (got.waiting_time !== e.waiting_time)
      report_mismatch($sformatf("process %0d waiting got %0d want %0d",
                                e.proc_index, got.waiting_time, e.waiting_time));
    if (got.last_result !== e.last_result)
      report_mismatch($sformatf("process %0d last flag got %0b want %0b",
                                e.proc_index, got.last_result, e.last_result));
  endtask

  task final_check();
    while (expected_times.size() != 0) begin
      report_mismatch($sformatf("no result for process %0d",
                                expected_times[0].proc_index));
      void'(expected_times.pop_front());
    end
  endtask
endclass

module round_robin_schedule_sim_core_tb;
  import rrs_pkg::*;

  localparam int                RandomItems = 150;
  localparam int                StallLimit  = 50000;
  localparam logic [PaddrW-1:0] QuantumAddr = {RegTimeQuantum, 2'b00};

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  in_item_t          item    = '0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PaddrW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic              busy;
  logic              result_strobe_o;
  out_item_t         result_o;
  logic [31:0]       prdata;
  logic              pready;

  schedule_scoreboard sb;
  int                 idle_cycles = 0;
  int                 items_sent = 0;
  int                 quantum_writes = 0;

  round_robin_schedule_sim_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Check every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_result(result_o);
  end

  // Count cycles in which no item and no result moves
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles without traffic", StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // Drop start for a random number of cycles; mostly short gaps
  task pause_sender(input bit steady);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (steady || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(20, 150);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Present one process item and hold it until the block takes it
  task send_proc(input logic [ValW-1:0] arrival, input logic [ValW-1:0] burst,
                 input logic last, input bit steady);
    in_item_t it;
    it.arrival_time = arrival;
    it.burst_time = burst;
    it.last_item = last;
    start <= 1'b1;
    item <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
    items_sent++;
    pause_sender(steady);
  endtask

  // Hold the sender until every expected result has come, then settle
  task drain_results();
    start <= 1'b0;
    while (sb.expected_times.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the quantum register and read it back
  task set_quantum(input logic [ValW-1:0] value);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= QuantumAddr;
    pwdata <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.quantum = value;
    quantum_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[ValW-1:0] !== value)
      sb.report_mismatch($sformatf("quantum readback got %0d want %0d", rd[ValW-1:0], value));
  endtask

  initial begin : stimulus
    int  arrival;
    int  burst;
    int  len;
    int  r;
    int  q_eff;
    int  bmax;
    int  random_items;
    bit  steady;
    sb = new();
    random_items = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset quantum of one: preemption every unit, one zero burst
    send_proc(16'd0, 16'd3, 1'b0, 1'b0);
    send_proc(16'd1, 16'd0, 1'b0, 1'b0);
    send_proc(16'd2, 16'd2, 1'b1, 1'b0);
    drain_results();

    // Largest quantum: latest arrival with longest burst, then arrivals out of order
    set_quantum(16'hFFFF);
    send_proc(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_proc(16'd500, 16'd10, 1'b0, 1'b0);
    send_proc(16'd20, 16'd5, 1'b0, 1'b0);
    send_proc(16'd600, 16'hFFFF, 1'b1, 1'b0);
    drain_results();

    // Quantum of zero acts as one
    set_quantum(16'd0);
    send_proc(16'd5, 16'd2, 1'b0, 1'b0);
    send_proc(16'd5, 16'd3, 1'b1, 1'b0);
    drain_results();

    // Overflow: the seventeenth item is dropped but still starts the run
    set_quantum(16'd3);
    for (int i = 0; i < 17; i++) send_proc(ValW'(i * 4), ValW'(i % 4), i == 16, 1'b1);
    drain_results();

    // Random lists: mostly ordered arrivals, some out of order or overfull
    while (random_items < RandomItems) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results();
        case ($urandom_range(0, 4))
          0: set_quantum(16'd1);
          1: set_quantum(ValW'($urandom_range(2, 8)));
          2: set_quantum(ValW'($urandom_range(9, 100)));
          3: set_quantum(16'hFFFF);
          default: set_quantum(ValW'($urandom_range(1, 65535)));
        endcase
      end else if ($urandom_range(0, 5) == 0) begin
        drain_results();
      end
      q_eff = (sb.quantum == '0) ? 1 : int'(sb.quantum);
      bmax = (q_eff <= 8) ? 40 : ((q_eff * 6 > 65535) ? 65535 : q_eff * 6);
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 10);
      else if (r < 95) len = $urandom_range(11, 16);
      else len = $urandom_range(17, 20);
      case ($urandom_range(0, 3))
        0: arrival = 0;
        1: arrival = $urandom_range(60000, 65535);
        default: arrival = $urandom_range(0, 65535);
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 7);
        if (r == 0) burst = 0;
        else if (r == 1) burst = bmax;
        else burst = $urandom_range(0, bmax);
        send_proc(arrival[ValW-1:0], burst[ValW-1:0], k == len - 1, steady);
        random_items++;
        // Advance the arrival clock, now and then out of order
        r = $urandom_range(0, 11);
        if (r == 0) arrival = $urandom_range(0, 65535);
        else if (r < 3) arrival = arrival + $urandom_range(0, 2000);
        else arrival = arrival + $urandom_range(0, 3);
        if (arrival > 65535) arrival = 65535;
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    sb.final_check();
    $display("Run covered %0d lists from %0d items under %0d quantum writes.",
             sb.lists_scheduled, items_sent, quantum_writes);
    $display("%0d per-process results compared, %0d mismatches.",
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rrs_pkg.sv
rtl/rrs_datapath.sv
rtl/rrs_ctrl.sv
rtl/round_robin_schedule_sim_core.sv
sim/round_robin_schedule_sim_core_tb.sv
